### hw/rtl/sqk_pkg.sv
// Package for the quartic spline kernel evaluator: widths, breakpoints,
// pipeline latencies, shared types and the output saturation function.
// No dependencies.
package sqk_pkg;

   // Fixed-point layout of the root and of the spline bases (Q.20).
   localparam int ROOT_W = 22;
   localparam int QSQ_W  = 24;
   localparam int DIV_W  = 63;

   localparam logic [ROOT_W-1:0] Q_HALF     = 22'h080000;
   localparam logic [ROOT_W-1:0] Q_ONE_HALF = 22'h180000;
   localparam logic [ROOT_W-1:0] Q_TWO_HALF = 22'h280000;

   // Breakpoints of the three spline terms, outermost first.
   localparam logic [ROOT_W-1:0] BREAKS [3] = '{Q_TWO_HALF, Q_ONE_HALF, Q_HALF};

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_SCALE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADIENT_SCALE = 1'b1;

   // Pipeline latencies in register levels.
   localparam int ROOT_LAT   = ROOT_W;
   localparam int SPLINE_LAT = 5;
   localparam int DIV_LAT    = DIV_W;
   localparam int GRAD_LAT   = 3;
   localparam int NUM_LEVEL  = ROOT_LAT + SPLINE_LAT + 1;
   localparam int DIV_OUT    = NUM_LEVEL + DIV_LAT;
   localparam int TOTAL_LAT  = DIV_OUT + GRAD_LAT;
   localparam int WEIGHT_DLY = TOTAL_LAT - (NUM_LEVEL + 1);
   localparam int DIST_DLY   = DIV_OUT;
   localparam int SIGN_DLY   = DIV_LAT;

   // Flags and root that travel beside the spline sums.
   typedef struct packed {
      logic              outside;
      logic              q_zero;
      logic [ROOT_W-1:0] q;
   } spline_side_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } dist_type;

   // Applies the sign to a truncated magnitude and saturates to 32 bits.
   function automatic logic [31:0] sat_result(input logic neg, input logic [70:0] m);
      logic [31:0] r;
      if (neg) begin
         if (m >= 71'h80000000) r = 32'h80000000;
         else r = 32'd0 - m[31:0];
      end else begin
         if (m > 71'h7FFFFFFF) r = 32'h7FFFFFFF;
         else r = m[31:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/sqk_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Turns Q4.20 q_sq into the Q2.20 distance Q. Uses sqk_pkg.
module sqk_isqrt (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [sqk_pkg::QSQ_W-1:0] q_sq,
   output logic [sqk_pkg::ROOT_W-1:0] root
);

   logic [22:0]                 rem_ff  [sqk_pkg::ROOT_W];
   logic [sqk_pkg::ROOT_W-1:0]  root_ff [sqk_pkg::ROOT_W];
   logic [sqk_pkg::QSQ_W-1:0]   qsq_ff  [sqk_pkg::ROOT_W];

   for (genvar k = 0; k < sqk_pkg::ROOT_W; k++) begin : g_stage
      logic [22:0]                rem_prev;
      logic [sqk_pkg::ROOT_W-1:0] root_prev;
      logic [sqk_pkg::QSQ_W-1:0]  qsq_prev;
      logic [43:0]                rad;
      logic [24:0]                cur;
      logic [24:0]                trial;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign qsq_prev  = q_sq;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign qsq_prev  = qsq_ff[k-1];
      end

      // Bring down the next pair of radicand bits and try the next root bit.
      assign rad   = {qsq_prev, 20'd0};
      assign cur   = {rem_prev, rad[43-2*k -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (adv) begin
            qsq_ff[k] <= qsq_prev;
            if (cur >= trial) begin
               rem_ff[k]  <= 23'(cur - trial);
               root_ff[k] <= {root_prev[sqk_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= cur[22:0];
               root_ff[k] <= {root_prev[sqk_pkg::ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[sqk_pkg::ROOT_W-1];

endmodule

### hw/rtl/sqk_spline.sv
// Quartic spline evaluation: bases, square, cube, fourth power and sums.
// Five register stages; uses sqk_pkg for breakpoints and the side struct.
module sqk_spline (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [sqk_pkg::ROOT_W-1:0]   q,
   output logic signed [31:0]           w,
   output logic signed [31:0]           d,
   output sqk_pkg::spline_side_type     side
);

   sqk_pkg::spline_side_type side_ff [sqk_pkg::SPLINE_LAT];

   logic [sqk_pkg::ROOT_W-1:0] base_in [3];
   logic [sqk_pkg::ROOT_W-1:0] b1_ff [3];
   logic [sqk_pkg::ROOT_W-1:0] b2_ff [3];
   logic [sqk_pkg::ROOT_W-1:0] b3_ff [3];
   logic [23:0] sq_ff [3];
   logic [23:0] cu_ff [3];
   logic [23:0] c4_ff [3];
   logic [25:0] fo_ff [3];
   logic [43:0] p_sq [3];
   logic [45:0] p_cu [3];
   logic [45:0] p_fo [3];
   logic signed [31:0] w_ff;
   logic signed [31:0] d_ff;
   logic signed [31:0] w_in;
   logic signed [31:0] d_in;

   // A term whose base is not positive drops out with a zero base.
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         base_in[t] = (q < sqk_pkg::BREAKS[t]) ? sqk_pkg::BREAKS[t] - q : '0;
         p_sq[t] = b1_ff[t] * b1_ff[t];
         p_cu[t] = sq_ff[t] * b2_ff[t];
         p_fo[t] = cu_ff[t] * b3_ff[t];
      end
   end

   // Weighted sums of the fourth powers and of the cubes.
   always_comb begin
      w_in = $signed({6'd0, fo_ff[0]}) - 32'sd5 * $signed({6'd0, fo_ff[1]})
           + 32'sd10 * $signed({6'd0, fo_ff[2]});
      d_in = $signed({8'd0, c4_ff[0]}) - 32'sd5 * $signed({8'd0, c4_ff[1]})
           + 32'sd10 * $signed({8'd0, c4_ff[2]});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].outside <= (q >= sqk_pkg::Q_TWO_HALF);
         side_ff[0].q_zero  <= (q == '0);
         side_ff[0].q       <= q;
         for (int s = 1; s < sqk_pkg::SPLINE_LAT; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int t = 0; t < 3; t++) begin
            b1_ff[t] <= base_in[t];
            sq_ff[t] <= p_sq[t][43:20];
            b2_ff[t] <= b1_ff[t];
            cu_ff[t] <= p_cu[t][43:20];
            b3_ff[t] <= b2_ff[t];
            fo_ff[t] <= p_fo[t][45:20];
            c4_ff[t] <= cu_ff[t];
         end
         w_ff <= w_in;
         d_ff <= d_in;
      end
   end

   assign w    = w_ff;
   assign d    = d_ff;
   assign side = side_ff[sqk_pkg::SPLINE_LAT-1];

endmodule

### hw/rtl/sqk_divider.sv
// Pipelined restoring divider for the gradient factor, one quotient bit
// per stage, on unsigned magnitudes. Uses sqk_pkg for widths.
module sqk_divider (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [sqk_pkg::DIV_W-1:0]   num,
   input  logic [sqk_pkg::ROOT_W-1:0]  den,
   output logic [sqk_pkg::DIV_W-1:0]   quo
);

   // Each stage shifts a numerator bit out at the top and a quotient bit in.
   logic [sqk_pkg::DIV_W-1:0]  nq_ff  [sqk_pkg::DIV_LAT];
   logic [sqk_pkg::ROOT_W-1:0] rem_ff [sqk_pkg::DIV_LAT];
   logic [sqk_pkg::ROOT_W-1:0] den_ff [sqk_pkg::DIV_LAT];

   for (genvar k = 0; k < sqk_pkg::DIV_LAT; k++) begin : g_stage
      logic [sqk_pkg::DIV_W-1:0]  nq_prev;
      logic [sqk_pkg::ROOT_W-1:0] rem_prev;
      logic [sqk_pkg::ROOT_W-1:0] den_prev;
      logic [sqk_pkg::ROOT_W:0]   cur;

      if (k == 0) begin : g_first
         assign nq_prev  = num;
         assign rem_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign nq_prev  = nq_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      assign cur = {rem_prev, nq_prev[sqk_pkg::DIV_W-1]};

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[k] <= den_prev;
            if (cur >= {1'b0, den_prev}) begin
               rem_ff[k] <= sqk_pkg::ROOT_W'(cur - {1'b0, den_prev});
               nq_ff[k]  <= {nq_prev[sqk_pkg::DIV_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= cur[sqk_pkg::ROOT_W-1:0];
               nq_ff[k]  <= {nq_prev[sqk_pkg::DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = nq_ff[sqk_pkg::DIV_LAT-1];

endmodule

### hw/rtl/sqk_grad_mul.sv
// One gradient component: factor magnitude times distance, shifted by 24
// and saturated, in three stages. Uses sqk_pkg for widths and saturation.
module sqk_grad_mul (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [sqk_pkg::DIV_W-1:0] f_mag,
   input  logic                      f_neg,
   input  logic signed [31:0]        vec,
   output logic [31:0]               grad
);

   logic [31:0] vec_mag;
   logic [63:0] pl_ff;
   logic [62:0] ph_ff;
   logic        neg1_ff;
   logic [94:0] sum;
   logic [70:0] m_ff;
   logic        neg2_ff;
   logic [31:0] grad_ff;

   assign vec_mag = vec[31] ? 32'd0 - vec : vec;
   assign sum     = {ph_ff, 32'd0} + {31'd0, pl_ff};

   // Partial products, then their sum, then saturation.
   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff   <= f_mag[31:0] * vec_mag;
         ph_ff   <= f_mag[sqk_pkg::DIV_W-1:32] * vec_mag;
         neg1_ff <= f_neg ^ vec[31];
         m_ff    <= sum[94:24];
         neg2_ff <= neg1_ff;
         grad_ff <= sqk_pkg::sat_result(neg2_ff, m_ff);
      end
   end

   assign grad = grad_ff;

endmodule

### hw/rtl/sph_quartic_kernel_eval.sv
// Top level of the quartic spline kernel evaluator: handshake, registers,
// weight path and delay lines. Uses sqk_pkg, sqk_isqrt, sqk_spline,
// sqk_divider and sqk_grad_mul.
//
//   Channel  Direction  Handshake                 Payload
//   req_     in         req_valid / req_ready     q_sq, dist_x, dist_y, dist_z
//   rsp_     out        rsp_valid / rsp_ready     weight, grad_x, grad_y, grad_z
//   csr_     in         csr_wr_en                 csr_index, csr_wdata
//
// One beat enters per cycle while the pipeline advances; results leave in the order of their beats.
// Most of the pipeline depth lies in the 22-stage square root and the 63-stage divider.
// All stages move together; while a result waits on rsp_ready the whole
// pipeline holds and req_ready is low. Reset clears the stage valid bits
// and both scale registers.
module sph_quartic_kernel_eval (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [23:0]                   req_q_sq,
   input  logic signed [31:0]            req_dist_x,
   input  logic signed [31:0]            req_dist_y,
   input  logic signed [31:0]            req_dist_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_weight,
   output logic signed [31:0]            rsp_grad_x,
   output logic signed [31:0]            rsp_grad_y,
   output logic signed [31:0]            rsp_grad_z,
   input  logic                          csr_wr_en,
   input  logic [sqk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   logic                        adv;
   logic [sqk_pkg::TOTAL_LAT-1:0] vld_ff;
   logic [31:0]                 value_scale_ff;
   logic [31:0]                 gradient_scale_ff;

   logic [sqk_pkg::ROOT_W-1:0]  root;
   logic signed [31:0]          w;
   logic signed [31:0]          d;
   sqk_pkg::spline_side_type    side;

   logic [31:0]                 gs_mag;
   logic [31:0]                 d_mag;
   logic [31:0]                 w_mag;
   logic [63:0]                 num_prod;
   logic                        grad_off;
   logic [sqk_pkg::DIV_W-1:0]   num_ff;
   logic [sqk_pkg::ROOT_W-1:0]  den_ff;
   logic                        num_neg_ff;
   logic [63:0]                 wprod_ff;
   logic                        w_neg_ff;
   logic                        outside_ff;
   logic [31:0]                 weight_ff;
   logic [31:0]                 wdly_ff  [sqk_pkg::WEIGHT_DLY];
   logic                        fneg_ff  [sqk_pkg::SIGN_DLY];
   sqk_pkg::dist_type           dist_ff  [sqk_pkg::DIST_DLY];
   logic [sqk_pkg::DIV_W-1:0]   quo;
   sqk_pkg::dist_type           dist_out;
   logic [31:0]                 grad_x;
   logic [31:0]                 grad_y;
   logic [31:0]                 grad_z;

   // Global advance: the pipeline moves unless a finished beat is stuck.
   assign adv       = !vld_ff[sqk_pkg::TOTAL_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[sqk_pkg::TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[sqk_pkg::TOTAL_LAT-2:0], req_valid};
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_scale_ff    <= '0;
         gradient_scale_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            sqk_pkg::CSR_VALUE_SCALE:    value_scale_ff    <= csr_wdata;
            sqk_pkg::CSR_GRADIENT_SCALE: gradient_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sqk_isqrt u_isqrt (
      .clock (clock),
      .adv   (adv),
      .q_sq  (req_q_sq),
      .root  (root)
   );

   sqk_spline u_spline (
      .clock (clock),
      .adv   (adv),
      .q     (root),
      .w     (w),
      .d     (d),
      .side  (side)
   );

   // Gradient numerator and weight product share one stage.
   assign gs_mag   = gradient_scale_ff[31] ? 32'd0 - gradient_scale_ff : gradient_scale_ff;
   assign d_mag    = d[31] ? 32'd0 - d : d;
   assign w_mag    = w[31] ? 32'd0 - w : w;
   assign num_prod = gs_mag * d_mag;
   assign grad_off = side.outside || side.q_zero;

   always_ff @(posedge clock) begin
      if (adv) begin
         // A zero numerator over a divisor of one yields a zero gradient.
         num_ff     <= grad_off ? '0 : num_prod[sqk_pkg::DIV_W-1:0];
         den_ff     <= grad_off ? sqk_pkg::ROOT_W'(1) : side.q;
         num_neg_ff <= gradient_scale_ff[31] ^ d[31];
         wprod_ff   <= value_scale_ff * w_mag;
         w_neg_ff   <= w[31];
         outside_ff <= side.outside;
         weight_ff  <= outside_ff ? '0
                     : sqk_pkg::sat_result(w_neg_ff, {35'd0, wprod_ff[63:28]});
      end
   end

   sqk_divider u_divider (
      .clock (clock),
      .adv   (adv),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo)
   );

   // Delay lines that line up the weight, factor sign and distance vector.
   always_ff @(posedge clock) begin
      if (adv) begin
         wdly_ff[0] <= weight_ff;
         for (int i = 1; i < sqk_pkg::WEIGHT_DLY; i++) begin
            wdly_ff[i] <= wdly_ff[i-1];
         end
         fneg_ff[0] <= num_neg_ff;
         for (int i = 1; i < sqk_pkg::SIGN_DLY; i++) begin
            fneg_ff[i] <= fneg_ff[i-1];
         end
         dist_ff[0] <= {req_dist_x, req_dist_y, req_dist_z};
         for (int i = 1; i < sqk_pkg::DIST_DLY; i++) begin
            dist_ff[i] <= dist_ff[i-1];
         end
      end
   end

   assign dist_out = dist_ff[sqk_pkg::DIST_DLY-1];

   sqk_grad_mul u_grad_x (
      .clock (clock),
      .adv   (adv),
      .f_mag (quo),
      .f_neg (fneg_ff[sqk_pkg::SIGN_DLY-1]),
      .vec   (dist_out.x),
      .grad  (grad_x)
   );

   sqk_grad_mul u_grad_y (
      .clock (clock),
      .adv   (adv),
      .f_mag (quo),
      .f_neg (fneg_ff[sqk_pkg::SIGN_DLY-1]),
      .vec   (dist_out.y),
      .grad  (grad_y)
   );

   sqk_grad_mul u_grad_z (
      .clock (clock),
      .adv   (adv),
      .f_mag (quo),
      .f_neg (fneg_ff[sqk_pkg::SIGN_DLY-1]),
      .vec   (dist_out.z),
      .grad  (grad_z)
   );

   assign rsp_weight = wdly_ff[sqk_pkg::WEIGHT_DLY-1];
   assign rsp_grad_x = grad_x;
   assign rsp_grad_y = grad_y;
   assign rsp_grad_z = grad_z;

endmodule

### sim/sph_quartic_kernel_eval_tb.sv
// Self-checking testbench for sph_quartic_kernel_eval: directed table, then random
// particle pairs with random idling on both channels, checked against a predictor.
// Depends on sqk_pkg and the sph_quartic_kernel_eval RTL.
`timescale 1ns / 1ps

module sph_quartic_kernel_eval_tb;

   localparam int LATENCY     = 94;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [63:0] PROD_CAP = 64'h4000000000000000;

   typedef struct packed {
      logic [23:0] q_sq;
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] dz;
   } pair_type;

   typedef struct packed {
      logic [31:0] weight;
      logic [31:0] gx;
      logic [31:0] gy;
      logic [31:0] gz;
   } kernel_type;

   // Directed row: the pair, and optionally a result typed in by hand.
   typedef struct {
      pair_type   pair;
      logic       known;
      kernel_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [23:0] req_q_sq = '0;
   logic signed [31:0] req_dist_x = '0, req_dist_y = '0, req_dist_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_weight, rsp_grad_x, rsp_grad_y, rsp_grad_z;
   logic csr_wr_en = 1'b0;
   logic [sqk_pkg::CSR_IDX_W-1:0] csr_index = sqk_pkg::CSR_VALUE_SCALE;
   logic [31:0] csr_wdata = '0;

   logic [31:0] value_scale_m;
   logic [31:0] gradient_scale_m;
   kernel_type  kernel_q [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          hold_off = 1'b0;

   sph_quartic_kernel_eval DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] root_of(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Product shifted right by sh with the magnitude truncated, then saturated.
   function automatic logic [31:0] scaled_product(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input int sh);
      logic [63:0] ua, ub, m;
      logic neg;
      ua = magnitude(a);
      ub = magnitude(b);
      neg = (a < 0) != (b < 0);
      if (ua == 0 || ub == 0) return 32'd0;
      if (ub > PROD_CAP / ua) return neg ? 32'h80000000 : 32'h7FFFFFFF;
      m = (ua * ub) >> sh;
      if (neg) return (m >= 64'h80000000) ? 32'h80000000 : 32'd0 - m[31:0];
      return (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
   endfunction

   function automatic kernel_type kernel_of(input pair_type p);
      kernel_type k;
      logic [63:0] q, sq, cu, fo;
      logic signed [63:0] w, d, f;
      logic [63:0] bases [3];
      logic signed [63:0] coef [3];
      bases = '{64'(sqk_pkg::Q_TWO_HALF), 64'(sqk_pkg::Q_ONE_HALF), 64'(sqk_pkg::Q_HALF)};
      coef = '{64'sd1, -64'sd5, 64'sd10};
      k = '0;
      w = 0;
      d = 0;
      q = root_of(64'(p.q_sq) << 20);
      if (q >= 64'(sqk_pkg::Q_TWO_HALF)) return k;
      // Each term counts only while its base stays positive.
      for (int i = 0; i < 3; i++) begin
         if (q < bases[i]) begin
            sq = ((bases[i] - q) * (bases[i] - q)) >> 20;
            cu = (sq * (bases[i] - q)) >> 20;
            fo = (cu * (bases[i] - q)) >> 20;
            w = w + coef[i] * $signed(fo);
            d = d + coef[i] * $signed(cu);
         end
      end
      k.weight = scaled_product($signed({32'd0, value_scale_m}), w, 28);
      if (q == 0) return k;
      f = (64'($signed(gradient_scale_m)) * d) / $signed(q);
      k.gx = scaled_product(f, 64'($signed(p.dx)), 24);
      k.gy = scaled_product(f, 64'($signed(p.dy)), 24);
      k.gz = scaled_product(f, 64'($signed(p.dz)), 24);
      return k;
   endfunction

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         if (gap > 2 && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each result beat with the oldest expected kernel value.
   always @(posedge clock) begin
      kernel_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kernel_q.size() == 0) begin
            $display("%0t: unexpected result beat weight=%h", $realtime, rsp_weight);
            error_count++;
         end else begin
            e = kernel_q.pop_front();
            if (rsp_weight !== e.weight || rsp_grad_x !== e.gx ||
                rsp_grad_y !== e.gy || rsp_grad_z !== e.gz) begin
               $display("%0t: expected w=%h gx=%h gy=%h gz=%h got w=%h gx=%h gy=%h gz=%h",
                        $realtime, e.weight, e.gx, e.gy, e.gz,
                        rsp_weight, rsp_grad_x, rsp_grad_y, rsp_grad_z);
               error_count++;
            end
         end
      end
   end

   // One register write; the write enable then drops and the port is left idle before the task returns.
   task automatic write_reg(input logic [sqk_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == sqk_pkg::CSR_VALUE_SCALE) value_scale_m = v;
      else gradient_scale_m = v;
      @(posedge clock);
   endtask

   // Offer one pair and wait for its beat; the expectation is queued at acceptance.
   // Valid drops only during an idle gap, so back-to-back pairs keep it high.
   task automatic send_pair(input pair_type p, input logic known, input kernel_type r);
      if ($urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end else if ($urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_q_sq <= p.q_sq;
      req_dist_x <= p.dx;
      req_dist_y <= p.dy;
      req_dist_z <= p.dz;
      do @(posedge clock); while (!req_ready);
      kernel_q.push_back(known ? r : kernel_of(p));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (kernel_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic pair_type random_pair();
      pair_type p;
      int sel;
      sel = $urandom_range(0, 9);
      // Mostly inside support, with breakpoints and extremes mixed in.
      if (sel < 6) p.q_sq = 24'($urandom_range(0, 24'h63FFFF));
      else if (sel == 6) p.q_sq = 24'($urandom_range(0, 24'hFFFFFF));
      else if (sel == 7) p.q_sq = 24'(($urandom_range(0, 6) << 20) + $urandom_range(0, 3));
      else if (sel == 8) p.q_sq = 24'($urandom_range(0, 40));
      else p.q_sq = 24'(24'h640000 - $urandom_range(0, 3));
      p.dx = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      p.dy = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      p.dz = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      return p;
   endfunction

   initial begin
      row_type rows [$];
      logic [31:0] vs [5];
      logic [31:0] gs [5];
      vs = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0, 32'h00A0_0000, $urandom()};
      gs = '{32'hFF00_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, $urandom()};
      value_scale_m = 0;
      gradient_scale_m = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Right after reset both scales are zero, so every result is zero.
      rows.push_back('{'{24'h040000, 32'h10000, -32'sh10000, 32'h7FFFFFFF}, 1'b1, '0});
      rows.push_back('{'{24'h000000, 32'h80000000, 32'h0, 32'h1}, 1'b1, '0});
      foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].res);
      drain();

      write_reg(sqk_pkg::CSR_VALUE_SCALE, 32'hFFFF_FFFF);
      write_reg(sqk_pkg::CSR_GRADIENT_SCALE, 32'h8000_0000);
      rows.delete();
      // Outside support is all zero; zero distance gives zero gradient.
      rows.push_back('{'{24'h640000, 32'h7FFFFFFF, 32'h80000000, 32'h1234}, 1'b1, '0});
      rows.push_back('{'{24'hFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000}, 1'b1, '0});
      rows.push_back('{'{24'h000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF}, 1'b0, '0});
      rows.push_back('{'{24'h000001, 32'h7FFFFFFF, 32'h80000000, 32'h00010000}, 1'b0, '0});
      rows.push_back('{'{24'h040000, 32'hAAAAAAAA, 32'h55555555, 32'h0}, 1'b0, '0});
      rows.push_back('{'{24'h03FFFF, 32'h00010000, 32'hFFFF0000, 32'h00008000}, 1'b0, '0});
      rows.push_back('{'{24'h240000, 32'h00010000, 32'hFFFF0000, 32'h00008000}, 1'b0, '0});
      rows.push_back('{'{24'h23FFFF, 32'h00020000, 32'hFFFE0000, 32'h7FFF0000}, 1'b0, '0});
      rows.push_back('{'{24'h63FFFF, 32'h00010000, 32'h00010000, 32'h00010000}, 1'b0, '0});
      rows.push_back('{'{24'h100000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF}, 1'b0, '0});
      foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].res);
      drain();

      // Random phases, one setting of the scales each.
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(sqk_pkg::CSR_VALUE_SCALE, vs[ph]);
         write_reg(sqk_pkg::CSR_GRADIENT_SCALE, gs[ph]);
         if (ph == 1) hold_off = 1'b1;
         for (int n = 0; n < 128; n++) send_pair(random_pair(), 1'b0, '0);
         drain();
      end

      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
